@@ hdl/ndvf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the near-duplicate vector filter.
// No dependencies.
package ndvf_pkg;

   localparam int ID_W       = 16;
   localparam int ELEM_W     = 16;
   localparam int COS_W      = 16;
   localparam int DIST_W     = 23;
   localparam int VLEN_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;
   // cosine test compares dot^2 * 2^COS_SHIFT against c^2 * n1 * n2
   localparam int COS_SHIFT  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_COSINE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH  = 2'd2;

   localparam logic [COS_W-1:0]  COS_RESET  = 16'd65208;
   localparam logic [DIST_W-1:0] DIST_RESET = 23'd0;
   localparam logic [VLEN_W-1:0] VLEN_RESET = 7'd64;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

@@ hdl/ndvf_mul.sv @@
`timescale 1ns / 1ps
// Serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ndvf_pkg (status struct).
module ndvf_mul #(
   parameter int W = 53
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [W-1:0]          op_a,
   input  logic [W-1:0]          op_b,
   output logic [2*W-1:0]        product,
   output ndvf_pkg::mul_stat_type stat
);

   localparam int CNTW = $clog2(W + 1);

   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0]   mcand_ff, mcand_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W:0]     sum;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sum      = {1'b0, acc_ff[2*W-1:W]} + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         acc_in   = {{W{1'b0}}, op_b};
         mcand_in = op_a;
         cnt_in   = CNTW'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[W-1:1]};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hdl/near_duplicate_vector_filter.sv @@
`timescale 1ns / 1ps
// Near-duplicate vector filter top level: element intake, stores, compare sequencer.
// Depends on ndvf_pkg and ndvf_mul.

// Feature vectors arrive one signed Q4.12 element per transfer. When a vector
// completes, it is compared with each of the S vectors stored earlier in the set,
// and the input stays not ready meanwhile. Each comparison reads one element pair
// per cycle from the feature memory. If the L1 test fails and both norms are
// nonzero, the cosine test runs four products through the shared serial multiplier
// (MW = 53 at default sizes). The loop stops at the first similar vector. A vector
// that finds the store full is reported at once with overflow set. A result waits
// in the output register while the next vector's elements are taken; the stores
// need no clearing pass after reset.
module near_duplicate_vector_filter #(
   parameter int MAX_DIM     = 64,
   parameter int MAX_VECTORS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // element input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_set,
   input  logic [ndvf_pkg::ID_W-1:0]           req_sample_id,
   input  logic signed [ndvf_pkg::ELEM_W-1:0]  req_element,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ndvf_pkg::ID_W-1:0]           rsp_result_id,
   output logic                                rsp_kept,
   output logic                                rsp_overflow,
   // configuration
   input  logic                                csr_we,
   input  logic [ndvf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ndvf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int VW   = $clog2(MAX_VECTORS);
   localparam int CW   = $clog2(MAX_VECTORS + 1);
   localparam int LENW = $clog2(MAX_DIM + 1);
   localparam int NW   = 31 + $clog2(MAX_DIM);   // squared norm
   localparam int MW   = NW + ndvf_pkg::COS_W;   // multiplier operand
   localparam int LW   = 17 + DW;                // L1 sum
   localparam int DKW  = (LW > ndvf_pkg::DIST_W) ? LW : ndvf_pkg::DIST_W;
   localparam int LX   = (LENW > ndvf_pkg::VLEN_W) ? LENW : ndvf_pkg::VLEN_W;
   localparam int FS_DEPTH = 2 ** (VW + DW);
   localparam int CMPW = 2 * MW + ndvf_pkg::COS_SHIFT;

   typedef enum logic [3:0] {
      S_IDLE, S_ELEM, S_DRAIN, S_TEST, S_MUL_GO, S_MUL_WAIT, S_CMP, S_DONE
   } state_type;

   typedef enum logic [1:0] {M_PC, M_P1, M_RHS, M_LHS} mul_sel_type;

   // configuration
   logic [ndvf_pkg::COS_W-1:0]  cos_limit_ff;
   logic [ndvf_pkg::DIST_W-1:0] dist_limit_ff;
   logic [ndvf_pkg::VLEN_W-1:0] vec_len_ff;

   // stores
   logic signed [ndvf_pkg::ELEM_W-1:0] feature_mem [FS_DEPTH];
   logic [NW-1:0]                      norm_mem [MAX_VECTORS];
   logic signed [ndvf_pkg::ELEM_W-1:0] rd_a_ff, rd_b_ff;
   logic [NW-1:0]                      norm_k_ff;
   logic                               fs_we, ns_we;
   logic [VW+DW-1:0]                   fs_waddr;
   logic [VW-1:0]                      ns_waddr;
   logic [NW-1:0]                      ns_wdata;

   // sequencer state
   state_type          state_ff, state_in;
   mul_sel_type        mul_sel_ff, mul_sel_in;
   logic [DW-1:0]      ec_ff, ec_in;
   logic [CW-1:0]      sc_ff, sc_in;
   logic [ndvf_pkg::ID_W-1:0] cur_id_ff, cur_id_in;
   logic [NW-1:0]      cur_norm_ff, cur_norm_in;
   logic [VW-1:0]      slot_ff, slot_in;
   logic [VW-1:0]      k_ff, k_in;
   logic [DW-1:0]      i_ff, i_in;
   logic signed [NW:0] dot_ff, dot_in;
   logic [LW-1:0]      l1_ff, l1_in;
   logic               acc_en_ff, acc_en_in;
   logic [NW-1:0]      mag_ff, mag_in;
   logic [MW-1:0]      pc_ff, pc_in, p1_ff, p1_in;
   logic [2*MW-1:0]    rhs_ff, rhs_in, lhs_ff, lhs_in;
   logic [ndvf_pkg::ID_W-1:0] res_id_ff, res_id_in;
   logic               res_kept_ff, res_kept_in, res_ovf_ff, res_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ndvf_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic               rsp_kept_ff, rsp_kept_in, rsp_ovf_ff, rsp_ovf_in;

   // helpers
   logic [LENW-1:0]    len;
   logic [LX-1:0]      vl_x;
   logic [DW-1:0]      len_m1;
   logic               accept;
   logic [DW-1:0]      ec_eff;
   logic [CW-1:0]      sc_eff;
   logic [NW-1:0]      norm_next;
   logic               full;
   logic signed [2*ndvf_pkg::ELEM_W-1:0] elem_sq, pair_prod;
   logic signed [ndvf_pkg::ELEM_W:0]     pair_diff;
   logic [ndvf_pkg::ELEM_W-1:0]          pair_absd;
   logic               l1_hit;
   logic               mul_start;
   logic [MW-1:0]      mul_a, mul_b;
   logic [2*MW-1:0]    mul_p;
   ndvf_pkg::mul_stat_type mul_stat;

   ndvf_mul #(.W(MW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .stat    (mul_stat)
   );

   // active length: zero counts as one, saturates at MAX_DIM
   always_comb begin
      vl_x = LX'(vec_len_ff);
      if (vec_len_ff == '0) begin
         len = LENW'(1);
      end else if (vl_x > LX'(MAX_DIM)) begin
         len = LENW'(MAX_DIM);
      end else begin
         len = LENW'(vl_x);
      end
      len_m1 = DW'(len - LENW'(1));
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign ec_eff    = req_start_set ? '0 : ec_ff;
   assign sc_eff    = req_start_set ? '0 : sc_ff;
   assign full      = (sc_eff >= CW'(MAX_VECTORS));
   assign elem_sq   = req_element * req_element;
   assign norm_next = ((ec_eff == '0) ? '0 : cur_norm_ff) + NW'($unsigned(elem_sq));

   assign pair_prod = rd_a_ff * rd_b_ff;
   assign pair_diff = {rd_a_ff[ndvf_pkg::ELEM_W-1], rd_a_ff}
                    - {rd_b_ff[ndvf_pkg::ELEM_W-1], rd_b_ff};
   assign pair_absd = pair_diff[ndvf_pkg::ELEM_W] ? ndvf_pkg::ELEM_W'(-pair_diff)
                                                   : pair_diff[ndvf_pkg::ELEM_W-1:0];
   assign l1_hit    = (DKW'(l1_ff) <= DKW'(dist_limit_ff));

   // operand select for the shared multiplier
   always_comb begin
      case (mul_sel_ff)
         M_PC: begin
            mul_a = MW'(cos_limit_ff);
            mul_b = MW'(cur_norm_ff);
         end
         M_P1: begin
            mul_a = MW'(cos_limit_ff);
            mul_b = MW'(norm_k_ff);
         end
         M_RHS: begin
            mul_a = pc_ff;
            mul_b = p1_ff;
         end
         default: begin
            mul_a = MW'(mag_ff);
            mul_b = MW'(mag_ff);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mul_sel_in   = mul_sel_ff;
      ec_in        = ec_ff;
      sc_in        = sc_ff;
      cur_id_in    = cur_id_ff;
      cur_norm_in  = cur_norm_ff;
      slot_in      = slot_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      dot_in       = dot_ff;
      l1_in        = l1_ff;
      acc_en_in    = (state_ff == S_ELEM);
      mag_in       = mag_ff;
      pc_in        = pc_ff;
      p1_in        = p1_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      res_id_in    = res_id_ff;
      res_kept_in  = res_kept_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mul_start    = 1'b0;
      fs_we        = 1'b0;
      fs_waddr     = {sc_eff[VW-1:0], ec_eff};
      ns_we        = 1'b0;
      ns_waddr     = sc_eff[VW-1:0];
      ns_wdata     = norm_next;

      if (acc_en_ff) begin
         dot_in = dot_ff + (NW+1)'(pair_prod);
         l1_in  = l1_ff + LW'(pair_absd);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sc_in     = sc_eff;
               fs_we     = !full;
               if (ec_eff == '0) begin
                  cur_id_in = req_sample_id;
               end
               res_id_in = (ec_eff == '0) ? req_sample_id : cur_id_ff;
               if (ec_eff < len_m1) begin
                  ec_in       = ec_eff + DW'(1);
                  cur_norm_in = norm_next;
               end else begin
                  ec_in       = '0;
                  cur_norm_in = norm_next;
                  res_ovf_in  = full;
                  res_kept_in = !full;
                  if (full) begin
                     state_in = S_DONE;
                  end else begin
                     ns_we   = 1'b1;
                     slot_in = sc_eff[VW-1:0];
                     sc_in   = sc_eff + CW'(1);
                     k_in    = '0;
                     i_in    = '0;
                     dot_in  = '0;
                     l1_in   = '0;
                     state_in = (sc_eff == '0) ? S_DONE : S_ELEM;
                  end
               end
            end
         end
         S_ELEM: begin
            i_in = i_ff + DW'(1);
            if (i_ff == len_m1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            mag_in = dot_ff[NW] ? NW'(-dot_ff) : dot_ff[NW-1:0];
            if (l1_hit) begin
               res_kept_in = 1'b0;
               state_in    = S_DONE;
            end else if (norm_k_ff == '0 || cur_norm_ff == '0) begin
               state_in = S_CMP;   // no cosine test; lhs/rhs forced below
               lhs_in   = '0;
               rhs_in   = '1;
            end else begin
               mul_sel_in = M_PC;
               state_in   = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_stat.done) begin
               case (mul_sel_ff)
                  M_PC: begin
                     pc_in      = mul_p[MW-1:0];
                     mul_sel_in = M_P1;
                     state_in   = S_MUL_GO;
                  end
                  M_P1: begin
                     p1_in      = mul_p[MW-1:0];
                     mul_sel_in = M_RHS;
                     state_in   = S_MUL_GO;
                  end
                  M_RHS: begin
                     rhs_in     = mul_p;
                     mul_sel_in = M_LHS;
                     state_in   = S_MUL_GO;
                  end
                  default: begin
                     lhs_in   = mul_p;
                     state_in = S_CMP;
                  end
               endcase
            end
         end
         S_CMP: begin
            if ({lhs_ff, {ndvf_pkg::COS_SHIFT{1'b0}}} >= CMPW'(rhs_ff)
                && !(lhs_ff == '0 && rhs_ff == '1)) begin
               res_kept_in = 1'b0;
               state_in    = S_DONE;
            end else if (k_ff + VW'(1) == slot_ff) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + VW'(1);
               i_in     = '0;
               dot_in   = '0;
               l1_in    = '0;
               state_in = S_ELEM;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_kept_in  = res_kept_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_sel_ff  <= mul_sel_in;
      slot_ff     <= slot_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      dot_ff      <= dot_in;
      l1_ff       <= l1_in;
      mag_ff      <= mag_in;
      pc_ff       <= pc_in;
      p1_ff       <= p1_in;
      rhs_ff      <= rhs_in;
      lhs_ff      <= lhs_in;
      res_id_ff   <= res_id_in;
      res_kept_ff <= res_kept_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         ec_ff         <= '0;
         sc_ff         <= '0;
         cur_id_ff     <= '0;
         cur_norm_ff   <= '0;
         acc_en_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cos_limit_ff  <= ndvf_pkg::COS_RESET;
         dist_limit_ff <= ndvf_pkg::DIST_RESET;
         vec_len_ff    <= ndvf_pkg::VLEN_RESET;
      end else begin
         state_ff     <= state_in;
         ec_ff        <= ec_in;
         sc_ff        <= sc_in;
         cur_id_ff    <= cur_id_in;
         cur_norm_ff  <= cur_norm_in;
         acc_en_ff    <= acc_en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               ndvf_pkg::CSR_COSINE_LIMIT:
                  cos_limit_ff <= csr_data[ndvf_pkg::COS_W-1:0];
               ndvf_pkg::CSR_DISTANCE_LIMIT:
                  dist_limit_ff <= csr_data[ndvf_pkg::DIST_W-1:0];
               ndvf_pkg::CSR_VECTOR_LENGTH:
                  vec_len_ff <= csr_data[ndvf_pkg::VLEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // feature memory: one write port, two registered read ports (stored k, current slot)
   always_ff @(posedge clock) begin
      if (fs_we) begin
         feature_mem[fs_waddr] <= req_element;
      end
      rd_a_ff <= feature_mem[{k_ff, i_ff}];
      rd_b_ff <= feature_mem[{slot_ff, i_ff}];
   end

   // norm memory
   always_ff @(posedge clock) begin
      if (ns_we) begin
         norm_mem[ns_waddr] <= ns_wdata;
      end
      norm_k_ff <= norm_mem[k_ff];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_kept      = rsp_kept_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // multiplier is only started when idle
   assert property (@(posedge clock) disable iff (reset) mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   // stored count never passes capacity
   assert property (@(posedge clock) disable iff (reset) sc_ff <= CW'(MAX_VECTORS))
      else $error("stored count beyond capacity");

   // compare loop only visits vectors stored before the current one
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_ELEM) |-> (k_ff < slot_ff))
      else $error("compare index past current slot");

endmodule
